FILE: hdl/sacache_pkg.sv
// ----------------------------------------------------------------------------
// sacache_pkg
// Shared types, sizes and helpers of the set-associative write-through cache.
// ----------------------------------------------------------------------------
package sacache_pkg;

  localparam int unsigned SETS          = 4;
  localparam int unsigned WAYS          = 4;
  localparam int unsigned BACKING_WORDS = 1024;
  localparam int unsigned DATA_WIDTH    = 32;

  localparam int unsigned KEY_W  = 10;
  localparam int unsigned WORD_W = 32;

  localparam int unsigned SET_W   = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int unsigned WAY_W   = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int unsigned BACK_AW = $clog2(BACKING_WORDS);
  localparam int unsigned LINE_W  = KEY_W + DATA_WIDTH;
  localparam int unsigned ROW_W   = WAYS * LINE_W;

  typedef enum logic [1:0] {
    REQ_WRITE   = 2'd0,
    REQ_LOOKUP  = 2'd1,
    REQ_BACKING = 2'd2,
    REQ_NONE    = 2'd3
  } req_type_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOK
  } state_t;

  typedef struct packed {
    req_type_t          req_type;
    logic [KEY_W-1:0]   key;
    logic [WORD_W-1:0]  write_data;
  } req_t;

  typedef struct packed {
    logic               hit;
    logic [WORD_W-1:0]  read_data;
  } resp_t;

  function automatic logic [DATA_WIDTH-1:0] fit_store(logic [WORD_W-1:0] d);
    logic [DATA_WIDTH-1:0] r;
    for (int i = 0; i < DATA_WIDTH; i++) begin
      r[i] = (i < WORD_W) ? d[i % WORD_W] : 1'b0;
    end
    return r;
  endfunction

  function automatic logic [WORD_W-1:0] fit_word(logic [DATA_WIDTH-1:0] d);
    logic [WORD_W-1:0] r;
    for (int i = 0; i < WORD_W; i++) begin
      r[i] = (i < DATA_WIDTH) ? d[i % DATA_WIDTH] : 1'b0;
    end
    return r;
  endfunction

endpackage

FILE: hdl/sacache_ram.sv
// ----------------------------------------------------------------------------
// sacache_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module sacache_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hdl/set_assoc_fifo_write_through_cache.sv
// ----------------------------------------------------------------------------
// set_assoc_fifo_write_through_cache
// Write-through, write-allocate set-associative cache with ring replacement
// in front of a directly addressed backing word store.
// ----------------------------------------------------------------------------
//  channel   ports                  handshake
//  request   start, busy, req       taken when start is high and busy is low
//  result    done, resp             valid for the single cycle done is high
//
//  an item is handled in order: in the cycle it is taken, the set row and
//  the backing word are read, then the compare and write-back step that
//  shows the result; busy is high during that step, so a new item is only
//  taken once the result of the last one has been shown.
//  after reset the backing store is zeroed, one word a cycle, with busy
//  high until every word is cleared. the receiver cannot stall results.
module set_assoc_fifo_write_through_cache (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  sacache_pkg::req_t  req,
  output logic               done,
  output sacache_pkg::resp_t resp
);
  import sacache_pkg::*;

  state_t state, state_next;

  logic [WAYS-1:0]    valid     [SETS];
  logic [WAY_W-1:0]   next_slot [SETS];
  logic [BACK_AW-1:0] clear_cnt;

  req_t               req_q;
  logic [SET_W-1:0]   set_q;
  logic [BACK_AW-1:0] addr_q;

  logic [SET_W-1:0]   set_in;
  logic [BACK_AW-1:0] addr_in;

  logic [ROW_W-1:0]      row_rd, row_wr;
  logic [DATA_WIDTH-1:0] back_rd;
  logic                  row_we, back_we;
  logic [BACK_AW-1:0]    back_waddr;
  logic [DATA_WIDTH-1:0] back_wdata;

  logic [WAYS-1:0]  match;
  logic             hit_any;
  logic [WAY_W-1:0] hit_way, tgt_way;
  logic             accept, clear_last;

  // both sizes are powers of two, so the remainders are plain masks
  assign set_in  = SET_W'(32'(req.key) % SETS);
  assign addr_in = BACK_AW'(32'(req.key) % BACKING_WORDS);
  assign accept  = start && !busy;
  assign clear_last = (clear_cnt == BACK_AW'(BACKING_WORDS - 1));

  sacache_ram #(.WIDTH(ROW_W), .DEPTH(SETS), .AW(SET_W)) u_rows (
    .clk   (clk),
    .we    (row_we),
    .waddr (set_q),
    .wdata (row_wr),
    .raddr (set_in),
    .rdata (row_rd)
  );

  sacache_ram #(.WIDTH(DATA_WIDTH), .DEPTH(BACKING_WORDS), .AW(BACK_AW)) u_backing (
    .clk   (clk),
    .we    (back_we),
    .waddr (back_waddr),
    .wdata (back_wdata),
    .raddr (addr_in),
    .rdata (back_rd)
  );

  // tag compare across the set row
  always_comb begin
    hit_any = 1'b0;
    hit_way = '0;
    for (int w = 0; w < WAYS; w++) begin
      match[w] = valid[set_q][w] && (row_rd[w*LINE_W + DATA_WIDTH +: KEY_W] == req_q.key);
    end
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (match[w]) begin
        hit_any = 1'b1;
        hit_way = WAY_W'(w);
      end
    end
  end

  assign tgt_way = hit_any ? hit_way : next_slot[set_q];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    busy       = 1'b1;
    done       = 1'b0;
    row_we     = 1'b0;
    back_we    = 1'b0;
    back_waddr = addr_q;
    back_wdata = fit_store(req_q.write_data);
    row_wr     = row_rd;
    row_wr[tgt_way*LINE_W +: LINE_W] = {req_q.key, fit_store(req_q.write_data)};
    resp.hit       = 1'b0;
    resp.read_data = '0;
    unique case (state)
      ST_CLEAR: begin
        back_we    = 1'b1;
        back_waddr = clear_cnt;
        back_wdata = '0;
        if (clear_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        busy = 1'b0;
        if (accept) begin
          state_next = ST_LOOK;
        end
      end
      ST_LOOK: begin
        done       = 1'b1;
        state_next = ST_IDLE;
        unique case (req_q.req_type)
          REQ_WRITE: begin
            resp.hit = hit_any;
            row_we   = 1'b1;
            back_we  = 1'b1;
          end
          REQ_LOOKUP: begin
            resp.hit = hit_any;
            if (hit_any) begin
              resp.read_data = fit_word(row_rd[hit_way*LINE_W +: DATA_WIDTH]);
            end
          end
          REQ_BACKING: begin
            resp.hit       = hit_any;
            resp.read_data = fit_word(back_rd);
          end
          REQ_NONE: begin
          end
        endcase
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clear_cnt <= '0;
      for (int s = 0; s < SETS; s++) begin
        valid[s]     <= '0;
        next_slot[s] <= '0;
      end
    end else begin
      if (state == ST_CLEAR) begin
        clear_cnt <= clear_cnt + BACK_AW'(1);
      end
      // allocation on a write miss advances the set's ring
      if (state == ST_LOOK && req_q.req_type == REQ_WRITE && !hit_any) begin
        valid[set_q][tgt_way] <= 1'b1;
        if (next_slot[set_q] == WAY_W'(WAYS - 1)) begin
          next_slot[set_q] <= '0;
        end else begin
          next_slot[set_q] <= next_slot[set_q] + WAY_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_q  <= req;
      set_q  <= set_in;
      addr_q <= addr_in;
    end
  end

endmodule
